### src/nmt_pkg.sv
// Package for the NAT mapping table: transfer payload types, codes, cell command
// and entry types, reset constants and the port allocator step function.
// No dependencies.
package nmt_pkg;

    localparam int DEF_ENTRIES = 64;

    localparam logic [15:0] RST_ICMP_TIMEOUT = 16'd60;
    localparam logic [15:0] RST_PORT_LOW     = 16'd1024;
    localparam logic [15:0] RST_PORT_HIGH    = 16'd65535;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_LOOKUP_INT = 2'd1,
        OP_LOOKUP_EXT = 2'd2,
        OP_TICK       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_TICK = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_ICMP_TIMEOUT = 2'd0,
        CFG_PORT_LOW     = 2'd1,
        CFG_PORT_HIGH    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_SCAN,
        S_COMPACT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_MATCH_INT,
        CMD_MATCH_EXT,
        CMD_MATCH_PORT,
        CMD_EXPIRE,
        CMD_SWAP
    } t_cmd_code;

    typedef struct packed {
        logic [1:0]  operation;
        logic        kind;
        logic [31:0] internal_ip;
        logic [15:0] internal_port;
        logic [15:0] external_port;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found_kind;
        logic [31:0] found_internal_ip;
        logic [15:0] found_internal_port;
        logic [15:0] found_external_port;
        logic [6:0]  expired_count;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [31:0] ip;
        logic [15:0] iport;
        logic [15:0] eport;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        t_cmd_code   code;
        logic        phase;
        logic        kind;
        logic [31:0] ip;
        logic [15:0] iport;
        logic [15:0] port;
        logic [31:0] seconds;
        logic [15:0] timeout;
        t_entry      wr_ent;
    } t_cell_cmd;

    // Advance the allocator by one, wrapping past the high port to the low port.
    function automatic logic [15:0] step_port(input logic [15:0] p,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [16:0] n;
        n = {1'b0, p} + 17'd1;
        if (n > {1'b0, hi}) begin
            return lo;
        end
        return n[15:0];
    endfunction

endpackage

### src/nmt_cell.sv
// One cell of the mapping table: holds one entry, matches it against the
// broadcast key, ages it out and trades places with a neighbor during compaction.
// Depends on nmt_pkg.
module nmt_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nmt_pkg::t_cell_cmd i_cmd,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  nmt_pkg::t_entry   i_lower,
    input  nmt_pkg::t_entry   i_upper,
    output nmt_pkg::t_entry   o_entry,
    output logic              o_hit
);
    import nmt_pkg::*;

    localparam logic PAR = 1'(IDX % 2);

    t_entry      r_ent, n_ent;
    logic        r_hit, n_hit;
    logic [31:0] w_age;

    assign w_age = i_cmd.seconds - r_ent.stamp;

    // Decode the broadcast command for this cell
    always_comb begin
        n_ent = r_ent;
        n_hit = r_hit;
        unique case (i_cmd.code)
            CMD_WRITE: begin
                if (i_wr_idx == IDX_W'(IDX)) begin
                    n_ent = i_cmd.wr_ent;
                end
            end
            CMD_MATCH_INT: begin
                n_hit = r_ent.valid && (r_ent.kind == i_cmd.kind) &&
                        (r_ent.ip == i_cmd.ip) && (r_ent.iport == i_cmd.iport);
            end
            CMD_MATCH_EXT: begin
                n_hit = r_ent.valid && (r_ent.kind == i_cmd.kind) &&
                        (r_ent.eport == i_cmd.port);
            end
            CMD_MATCH_PORT: begin
                n_hit = r_ent.valid && (r_ent.eport == i_cmd.port);
            end
            CMD_EXPIRE: begin
                n_hit = r_ent.valid && !r_ent.kind && (w_age > {16'd0, i_cmd.timeout});
                if (n_hit) begin
                    n_ent.valid = 1'b0;
                end
            end
            CMD_SWAP: begin
                // lower cell of a pair pulls a valid entry down into its hole
                if (PAR == i_cmd.phase) begin
                    if (!r_ent.valid && i_upper.valid) begin
                        n_ent = i_upper;
                    end
                end else if (IDX > 0) begin
                    if (r_ent.valid && !i_lower.valid) begin
                        n_ent = i_lower;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Hold the entry; only its valid bit and the hit flag are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_ent <= n_ent;
            r_hit <= n_hit;
        end
    end

    assign o_entry = r_ent;
    assign o_hit   = r_hit;

endmodule

### src/nat_mapping_table.sv
// NAT mapping table: a chain of ENTRIES cells kept oldest first, with a sequencer.
// Insert and lookups scan the cells' match flags serially, up to the fill count; a
// full insert skips the scan. Tick runs the odd-even compaction rounds. One item
// at a time; the next is taken once the result sits in the output register.
// Reset: synchronous, clears all valid bits, the clock and restores the registers.
module nat_mapping_table #(
    parameter int ENTRIES = nmt_pkg::DEF_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nmt_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output nmt_pkg::t_result  o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import nmt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    t_state           r_state, n_state;
    t_in_item         r_item, n_item;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_lim, n_lim;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_removed, n_removed;
    logic [CNT_W-1:0] w_rem_sum;
    logic [15:0]      r_next_port, n_next_port;
    logic [15:0]      r_cand, n_cand;
    logic [31:0]      r_seconds, n_seconds;
    logic [15:0]      r_timeout, r_port_low, r_port_high;
    t_result          r_res, n_res;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;

    t_cell_cmd        w_cmd;
    logic [IDX_W-1:0] w_wr_idx;
    t_entry           w_ent [ENTRIES];
    logic [ENTRIES-1:0] w_hit;
    t_entry           w_sel;
    logic             w_hit_k;

    // Chain of cells, each wired to its two neighbors
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_lo, w_up;
        if (g == 0) begin : g_lo0
            assign w_lo = '0;
        end else begin : g_lo
            assign w_lo = w_ent[g-1];
        end
        if (g == ENTRIES - 1) begin : g_upn
            assign w_up = '0;
        end else begin : g_up
            assign w_up = w_ent[g+1];
        end
        nmt_cell #(.IDX(g), .IDX_W(IDX_W)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd),
            .i_wr_idx (w_wr_idx),
            .i_lower  (w_lo),
            .i_upper  (w_up),
            .o_entry  (w_ent[g]),
            .o_hit    (w_hit[g])
        );
    end

    assign w_sel     = w_ent[r_k[IDX_W-1:0]];
    assign w_hit_k   = w_hit[r_k[IDX_W-1:0]];
    assign w_rem_sum = r_removed + CNT_W'(w_hit_k);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer: next state, cell commands and result
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_lim       = r_lim;
        n_k         = r_k;
        n_removed   = r_removed;
        n_next_port = r_next_port;
        n_cand      = r_cand;
        n_seconds   = r_seconds;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_cmd       = '0;
        w_cmd.code  = CMD_NONE;
        w_wr_idx    = r_count[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_lim   = r_count;
                    n_state = S_MATCH;
                    unique case (t_op'(i_in_data.operation))
                        OP_INSERT: begin
                            if (r_count == CNT_W'(ENTRIES)) begin
                                n_res        = '0;
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                w_cmd.code         = CMD_WRITE;
                                w_cmd.wr_ent.valid = 1'b1;
                                w_cmd.wr_ent.kind  = i_in_data.kind;
                                w_cmd.wr_ent.ip    = i_in_data.internal_ip;
                                w_cmd.wr_ent.iport = i_in_data.internal_port;
                                w_cmd.wr_ent.eport = r_next_port;
                                w_cmd.wr_ent.stamp = r_seconds;
                                n_res.status              = ST_OK;
                                n_res.found_kind          = i_in_data.kind;
                                n_res.found_internal_ip   = i_in_data.internal_ip;
                                n_res.found_internal_port = i_in_data.internal_port;
                                n_res.found_external_port = r_next_port;
                                n_res.expired_count       = '0;
                                n_count = r_count + CNT_W'(1);
                                n_cand  = step_port(r_next_port, r_port_low, r_port_high);
                            end
                        end
                        OP_TICK: begin
                            n_seconds = r_seconds + 32'd1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MATCH: begin
                w_cmd.kind    = r_item.kind;
                w_cmd.ip      = r_item.internal_ip;
                w_cmd.iport   = r_item.internal_port;
                w_cmd.seconds = r_seconds;
                w_cmd.timeout = r_timeout;
                n_k           = '0;
                n_removed     = '0;
                n_state       = S_SCAN;
                unique case (t_op'(r_item.operation))
                    OP_INSERT: begin
                        w_cmd.code = CMD_MATCH_PORT;
                        w_cmd.port = r_cand;
                    end
                    OP_LOOKUP_INT: begin
                        w_cmd.code = CMD_MATCH_INT;
                    end
                    OP_LOOKUP_EXT: begin
                        w_cmd.code = CMD_MATCH_EXT;
                        w_cmd.port = r_item.external_port;
                    end
                    OP_TICK: begin
                        w_cmd.code = CMD_EXPIRE;
                        n_state    = S_COMPACT;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // walk the match flags oldest first
                if (r_k == r_lim) begin
                    if (r_item.operation == OP_INSERT) begin
                        n_next_port = r_cand;
                    end else begin
                        n_res        = '0;
                        n_res.status = ST_MISS;
                    end
                    n_state = S_DONE;
                end else if (w_hit_k) begin
                    if (r_item.operation == OP_INSERT) begin
                        n_next_port = step_port(r_cand, r_port_low, r_port_high);
                    end else begin
                        n_res.status              = ST_OK;
                        n_res.found_kind          = w_sel.kind;
                        n_res.found_internal_ip   = w_sel.ip;
                        n_res.found_internal_port = w_sel.iport;
                        n_res.found_external_port = w_sel.eport;
                        n_res.expired_count       = '0;
                    end
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            S_COMPACT: begin
                // one odd-even round per cycle; tally expired flags meanwhile
                w_cmd.code  = CMD_SWAP;
                w_cmd.phase = r_k[0];
                n_removed   = w_rem_sum;
                n_k         = r_k + CNT_W'(1);
                if (r_k == CNT_W'(ENTRIES - 1)) begin
                    n_res               = '0;
                    n_res.status        = ST_TICK;
                    n_res.expired_count = 7'(w_rem_sum);
                    n_count             = r_count - w_rem_sum;
                    n_state             = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, counters and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_port <= RST_PORT_LOW;
            r_seconds   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_port <= n_next_port;
            r_seconds   <= n_seconds;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_lim     <= n_lim;
        r_k       <= n_k;
        r_removed <= n_removed;
        r_cand    <= n_cand;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= RST_ICMP_TIMEOUT;
            r_port_low  <= RST_PORT_LOW;
            r_port_high <= RST_PORT_HIGH;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ICMP_TIMEOUT: r_timeout   <= i_cfg_data;
                CFG_PORT_LOW:     r_port_low  <= i_cfg_data;
                CFG_PORT_HIGH:    r_port_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

### bench/tb_nat_mapping_table.sv
// Testbench for nat_mapping_table: directed and random table operations with
// a behavioral table model, scoreboard and random idling on both channels.
// Depends on nmt_pkg and nat_mapping_table.
`timescale 1ns / 1ps

module tb_nat_mapping_table;
    import nmt_pkg::*;

    localparam int NCELL = 64;
    localparam int LIMIT = 2000000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_item i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_result  o_out_data;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    nat_mapping_table #(.ENTRIES(NCELL)) uut (.*);

    // Shadow of the table contents and registers
    typedef struct {
        bit          vld;
        bit          kind;
        bit [31:0]   ip;
        bit [15:0]   iport;
        bit [15:0]   eport;
        bit [31:0]   stamp;
    } t_shadow_cell;

    t_shadow_cell tbl [NCELL];
    bit [15:0] timeout_reg, lo_reg, hi_reg, alloc_port;
    bit [31:0] clock_sec;
    t_result   pending_results [$];
    int        errors, sent, checked, cycles, n_full, n_hit, n_miss, n_expired;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit [15:0] next_alloc(bit [15:0] p);
        bit [16:0] n;
        n = {1'b0, p} + 17'd1;
        if (n > {1'b0, hi_reg}) return lo_reg;
        return n[15:0];
    endfunction

    function automatic bit port_in_use(bit [15:0] p);
        foreach (tbl[i]) if (tbl[i].vld && tbl[i].eport == p) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_result hit_result(int i);
        t_result r;
        r = '0;
        r.status = ST_OK;
        r.found_kind = tbl[i].kind;
        r.found_internal_ip = tbl[i].ip;
        r.found_internal_port = tbl[i].iport;
        r.found_external_port = tbl[i].eport;
        return r;
    endfunction

    // Compute the expected result and update the table shadow
    function automatic t_result translate(t_in_item it);
        t_result r;
        int slot, w, hit;
        bit [6:0] gone;
        r = '0;
        slot = -1;
        hit = -1;
        w = 0;
        gone = '0;
        case (t_op'(it.operation))
            OP_INSERT: begin
                foreach (tbl[i]) if (!tbl[i].vld && slot < 0) slot = i;
                if (slot < 0) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    tbl[slot].kind = it.kind;
                    tbl[slot].ip = it.internal_ip;
                    tbl[slot].iport = it.internal_port;
                    tbl[slot].eport = alloc_port;
                    tbl[slot].stamp = clock_sec;
                    alloc_port = next_alloc(alloc_port);
                    if (port_in_use(alloc_port)) alloc_port = next_alloc(alloc_port);
                    tbl[slot].vld = 1'b1;
                    r = hit_result(slot);
                end
            end
            OP_LOOKUP_INT, OP_LOOKUP_EXT: begin
                foreach (tbl[i]) begin
                    if (hit < 0 && tbl[i].vld && tbl[i].kind == it.kind &&
                        ((it.operation == OP_LOOKUP_INT) ?
                         (tbl[i].ip == it.internal_ip && tbl[i].iport == it.internal_port) :
                         (tbl[i].eport == it.external_port)))
                        hit = i;
                end
                if (hit < 0) begin
                    r.status = ST_MISS;
                    n_miss++;
                end else begin
                    r = hit_result(hit);
                    n_hit++;
                end
            end
            default: begin
                clock_sec++;
                foreach (tbl[i]) begin
                    if (tbl[i].vld) begin
                        if (!tbl[i].kind && (clock_sec - tbl[i].stamp) > timeout_reg)
                            gone++;
                        else begin
                            tbl[w] = tbl[i];
                            w++;
                        end
                    end
                end
                for (int i = w; i < NCELL; i++) tbl[i].vld = 1'b0;
                r.status = ST_TICK;
                r.expired_count = gone;
                n_expired += gone;
            end
        endcase
        return r;
    endfunction

    // Send one item after a random gap; valid stays high for a back-to-back item
    task automatic send_item(t_in_item it);
        int gap;
        gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(translate(it));
        sent++;
    endtask

    task automatic send_op(t_op op, bit kind, bit [31:0] ip, bit [15:0] ip_port,
                           bit [15:0] ext_port);
        t_in_item it;
        it.operation = op;
        it.kind = kind;
        it.internal_ip = ip;
        it.internal_port = ip_port;
        it.external_port = ext_port;
        send_item(it);
    endtask

    // Hold a register write until idle
    task automatic write_reg(t_cfg_idx idx, bit [15:0] val);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NCELL + 8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ICMP_TIMEOUT: timeout_reg = val;
            CFG_PORT_LOW:     lo_reg = val;
            default:          hi_reg = val;
        endcase
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                checked++;
                if (o_out_data.status !== exp_r.status ||
                    o_out_data.found_kind !== exp_r.found_kind ||
                    o_out_data.found_internal_ip !== exp_r.found_internal_ip ||
                    o_out_data.found_internal_port !== exp_r.found_internal_port ||
                    o_out_data.found_external_port !== exp_r.found_external_port ||
                    o_out_data.expired_count !== exp_r.expired_count) begin
                    $display("%0t: expected %h actual %h", $time, exp_r, o_out_data);
                    errors++;
                end
            end
        end
    end

    // Stall the result side at random
    initial begin
        int hold;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready)
                    hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
        end
    end

    task automatic test_directed();
        send_op(OP_LOOKUP_INT, 1'b0, 32'h0, 16'h0, 16'h0);
        send_op(OP_INSERT, 1'b0, 32'h0, 16'h0, 16'h0);
        send_op(OP_INSERT, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_op(OP_INSERT, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
        send_op(OP_LOOKUP_INT, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
        send_op(OP_LOOKUP_INT, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
        send_op(OP_LOOKUP_EXT, 1'b0, 32'h0, 16'h0, 16'd1024);
        send_op(OP_LOOKUP_EXT, 1'b1, 32'h0, 16'h0, 16'd1025);
        send_op(OP_LOOKUP_EXT, 1'b1, 32'h0, 16'h0, 16'hFFFF);
        send_op(OP_TICK, 1'b0, 32'h0, 16'h0, 16'h0);
    endtask

    task automatic test_timeout_zero();
        write_reg(CFG_ICMP_TIMEOUT, 16'd0);
        send_op(OP_INSERT, 1'b0, 32'h0A00_0001, 16'd7, 16'd0);
        send_op(OP_TICK, 1'b0, 32'h0, 16'h0, 16'h0);
        send_op(OP_TICK, 1'b1, 32'h0, 16'h0, 16'h0);
        send_op(OP_LOOKUP_INT, 1'b0, 32'h0A00_0001, 16'd7, 16'd0);
    endtask

    // Fill the table, overflow it, then drain the ICMP cells
    task automatic test_full_table();
        write_reg(CFG_ICMP_TIMEOUT, 16'd1);
        while (!tbl[NCELL-1].vld)
            send_op(OP_INSERT, 1'($urandom_range(0, 1)), $urandom, 16'($urandom), 16'h0);
        send_op(OP_INSERT, 1'b0, 32'h1, 16'h1, 16'h0);
        send_op(OP_INSERT, 1'b1, 32'h2, 16'h2, 16'h0);
        repeat (3) send_op(OP_TICK, 1'b0, 32'h0, 16'h0, 16'h0);
    endtask

    // Narrow and inverted port ranges exercise wrap and skip
    task automatic test_port_wrap();
        write_reg(CFG_PORT_LOW, 16'd65533);
        write_reg(CFG_PORT_HIGH, 16'd65535);
        repeat (8) send_op(OP_INSERT, 1'b0, $urandom, 16'($urandom), 16'h0);
        write_reg(CFG_PORT_LOW, 16'd0);
        write_reg(CFG_PORT_HIGH, 16'd3);
        repeat (8) send_op(OP_INSERT, 1'b1, $urandom, 16'($urandom), 16'h0);
        write_reg(CFG_PORT_LOW, 16'd500);
        write_reg(CFG_PORT_HIGH, 16'd100);
        repeat (4) send_op(OP_INSERT, 1'b0, $urandom, 16'($urandom), 16'h0);
        repeat (3) send_op(OP_TICK, 1'b0, 32'h0, 16'h0, 16'h0);
    endtask

    // Random traffic that reuses keys of stored entries so lookups hit often
    task automatic test_random(int count, bit [15:0] tmo, bit [15:0] lo, bit [15:0] hi);
        t_in_item it;
        int pick, c;
        write_reg(CFG_ICMP_TIMEOUT, tmo);
        write_reg(CFG_PORT_LOW, lo);
        write_reg(CFG_PORT_HIGH, hi);
        repeat (count) begin
            it.operation = 2'($urandom_range(0, 3));
            it.kind = 1'($urandom_range(0, 1));
            it.internal_ip = $urandom;
            it.internal_port = 16'($urandom);
            it.external_port = 16'($urandom);
            pick = $urandom_range(0, NCELL - 1);
            c = $urandom_range(0, 9);
            if (tbl[pick].vld && c < 7) begin
                it.kind = (c < 6) ? tbl[pick].kind : it.kind;
                it.internal_ip = tbl[pick].ip;
                it.internal_port = tbl[pick].iport;
                it.external_port = tbl[pick].eport;
            end
            if (it.operation == OP_TICK && $urandom_range(0, 1)) it.operation = OP_INSERT;
            send_item(it);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ICMP_TIMEOUT;
        i_cfg_data = '0;
        errors = 0; sent = 0; checked = 0; cycles = 0;
        n_full = 0; n_hit = 0; n_miss = 0; n_expired = 0;
        foreach (tbl[i]) tbl[i] = '{default: 0};
        timeout_reg = RST_ICMP_TIMEOUT;
        lo_reg = RST_PORT_LOW;
        hi_reg = RST_PORT_HIGH;
        alloc_port = RST_PORT_LOW;
        clock_sec = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_timeout_zero();
        test_full_table();
        test_port_wrap();
        test_random(160, 16'd3, 16'd1024, 16'd65535);
        test_random(120, 16'hFFFF, 16'd10, 16'd40);
        test_random(120, 16'd0, 16'hFFF0, 16'hFFFF);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NCELL + 20) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results", sent, checked);
        $display("Hits %0d, misses %0d, full drops %0d, expired %0d",
                 n_hit, n_miss, n_full, n_expired);
        if (errors == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
src/nmt_pkg.sv
src/nmt_cell.sv
src/nat_mapping_table.sv
bench/tb_nat_mapping_table.sv
